[rtl/core/piano_key_report_decoder_macros.svh]
// Assertion macros shared by the checker of the piano key report decoder.
`ifndef PIANO_KEY_REPORT_DECODER_MACROS_SVH
`define PIANO_KEY_REPORT_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PKD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pkd_pkg.sv]
// Types and constants of the piano key report decoder.
package pkd_pkg;

  localparam logic [7:0] ID_NOTES    = 8'h03;
  localparam logic [7:0] ID_MASK     = 8'h04;
  localparam logic [7:0] PRESS_LIMIT = 8'h81;
  localparam logic [7:0] PRESS_OFS   = 8'(8'h54 - 60);
  localparam logic [7:0] RELEASE_OFS = 8'(8'h94 - 60);
  localparam logic [15:0] VEL_RESET  = 16'h8000;
  localparam int unsigned MASK_BITS  = 24;
  localparam int unsigned QUERY_W    = 7;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_NOTES,
    KIND_MASK_WAIT,
    KIND_MASK_DONE
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PRESS,
    OP_RELEASE,
    OP_MASK
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [7:0]           key;
    logic [7:0]           vel;
    logic [MASK_BITS-1:0] mask;
    logic                 done;
    logic                 handled;
    logic [QUERY_W-1:0]   query;
  } op_t;

  typedef struct packed {
    logic               done;
    logic               handled;
    logic               button;
    logic signed [15:0] velocity;
  } res_t;

endpackage

[rtl/core/pkd_in_if.sv]
// Input byte channel of the piano key report decoder.
interface pkd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       last_byte;
  logic [6:0] query_button;

  modport source (output valid, output report_byte, output last_byte,
                  output query_button, input ready);
  modport sink (input valid, input report_byte, input last_byte,
                input query_button, output ready);
endinterface

[rtl/core/pkd_out_if.sv]
// Result channel of the piano key report decoder.
interface pkd_out_if;
  logic               valid;
  logic               ready;
  logic               report_done;
  logic               report_handled;
  logic               button_down;
  logic signed [15:0] last_velocity;

  modport source (output valid, output report_done, output report_handled,
                  output button_down, output last_velocity, input ready);
  modport sink (input valid, input report_done, input report_handled,
                input button_down, input last_velocity, output ready);
endinterface

[rtl/core/pkd_front.sv]
// Front end: parses report bytes and turns each into a key operation.
module pkd_front #(
  parameter int unsigned NOTE_KEYS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        report_byte_i,
  input  logic                              last_byte_i,
  input  logic [pkd_pkg::QUERY_W-1:0]       query_button_i,
  output logic                              op_valid_o,
  input  logic                              op_ready_i,
  output pkd_pkg::op_t                      op_o
);

  logic [1:0]     pos_q, pos_d;
  pkd_pkg::kind_e kind_q, kind_d, kind_n;
  logic [7:0]     held_q, held_d;
  logic [15:0]    mask_hi_q, mask_hi_d;
  logic [7:0]     key_sub;
  logic           accept;

  assign in_ready_o = op_ready_i;
  assign op_valid_o = in_valid_i;
  assign accept     = in_valid_i && op_ready_i;

  always_comb begin
    pos_d     = pos_q;
    kind_n    = kind_q;
    held_d    = held_q;
    mask_hi_d = mask_hi_q;
    key_sub   = '0;
    op_o         = '0;
    op_o.op      = pkd_pkg::OP_NONE;
    op_o.vel     = report_byte_i;
    op_o.done    = last_byte_i;
    op_o.query   = query_button_i;
    op_o.mask    = {mask_hi_q, report_byte_i};
    if (pos_q == 2'd0) begin
      if (report_byte_i == pkd_pkg::ID_NOTES) begin
        kind_n = pkd_pkg::KIND_NOTES;
      end else if (report_byte_i == pkd_pkg::ID_MASK) begin
        kind_n = pkd_pkg::KIND_MASK_WAIT;
      end else begin
        kind_n = pkd_pkg::KIND_NONE;
      end
      pos_d = 2'd1;
    end else if (kind_q == pkd_pkg::KIND_NOTES) begin
      if (pos_q == 2'd1) begin
        held_d = report_byte_i;
        pos_d  = 2'd2;
      end else begin
        pos_d = 2'd1;
        if (held_q < pkd_pkg::PRESS_LIMIT) begin
          key_sub = held_q - pkd_pkg::PRESS_OFS;
          if (held_q >= pkd_pkg::PRESS_OFS && int'(key_sub) < NOTE_KEYS) begin
            op_o.op = pkd_pkg::OP_PRESS;
          end
        end else begin
          key_sub = held_q - pkd_pkg::RELEASE_OFS;
          if (int'(key_sub) < NOTE_KEYS) begin
            op_o.op = pkd_pkg::OP_RELEASE;
          end
        end
      end
    end else if (kind_q == pkd_pkg::KIND_MASK_WAIT) begin
      if (pos_q == 2'd1) begin
        mask_hi_d = {report_byte_i, 8'h00};
        pos_d     = 2'd2;
      end else if (pos_q == 2'd2) begin
        mask_hi_d = {mask_hi_q[15:8], report_byte_i};
        pos_d     = 2'd3;
      end else begin
        op_o.op = pkd_pkg::OP_MASK;
        kind_n  = pkd_pkg::KIND_MASK_DONE;
      end
    end
    op_o.key = key_sub;
    kind_d   = kind_n;
    if (last_byte_i) begin
      op_o.handled = (kind_n == pkd_pkg::KIND_NOTES) || (kind_n == pkd_pkg::KIND_MASK_DONE);
      pos_d        = 2'd0;
      kind_d       = pkd_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 2'd0;
      kind_q    <= pkd_pkg::KIND_NONE;
      held_q    <= '0;
      mask_hi_q <= '0;
    end else if (accept) begin
      pos_q     <= pos_d;
      kind_q    <= kind_d;
      held_q    <= held_d;
      mask_hi_q <= mask_hi_d;
    end
  end

endmodule

[rtl/core/pkd_queue.sv]
// Two-entry operation queue between the front end and the key store.
module pkd_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  pkd_pkg::op_t push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output pkd_pkg::op_t pop_data_o
);

  pkd_pkg::op_t mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q, cnt_d;
  logic         push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/pkd_back.sv]
// Back end: applies key operations to the key store and registers results.
module pkd_back #(
  parameter int unsigned NOTE_KEYS = 48,
  parameter int unsigned MASK_KEYS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  output logic          op_ready_o,
  input  pkd_pkg::op_t  op_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output pkd_pkg::res_t res_o
);

  localparam int unsigned TotalKeys = NOTE_KEYS + MASK_KEYS;
  localparam int unsigned KeyW      = (TotalKeys > 1) ? $clog2(TotalKeys) : 1;

  logic [TotalKeys-1:0] keys_q, keys_d;
  logic [15:0]          vel_q, vel_d;
  logic [7:0]           vel_raw;
  logic                 res_valid_q;
  pkd_pkg::res_t        res_q, res_d;
  logic                 pop;

  assign op_ready_o  = !res_valid_q || res_ready_i;
  assign pop         = op_valid_i && op_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign vel_raw     = (op_i.vel == 8'h00) ? 8'h01 : op_i.vel;

  always_comb begin
    keys_d = keys_q;
    vel_d  = vel_q;
    case (op_i.op)
      pkd_pkg::OP_PRESS: begin
        keys_d[KeyW'(op_i.key)] = 1'b1;
        vel_d = {vel_raw, vel_raw} ^ pkd_pkg::VEL_RESET;
      end
      pkd_pkg::OP_RELEASE: begin
        keys_d[KeyW'(op_i.key)] = 1'b0;
      end
      pkd_pkg::OP_MASK: begin
        for (int b = 0; b < MASK_KEYS; b++) begin
          keys_d[NOTE_KEYS + b] = op_i.mask[b];
        end
      end
      default: begin
      end
    endcase
    res_d.done     = op_i.done;
    res_d.handled  = op_i.handled;
    res_d.velocity = $signed(vel_d);
    res_d.button   = (int'(op_i.query) < TotalKeys) ? keys_d[KeyW'(op_i.query)] : 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q      <= '0;
      vel_q       <= pkd_pkg::VEL_RESET;
      res_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        keys_q <= keys_d;
        vel_q  <= vel_d;
      end
      if (op_ready_o) begin
        res_valid_q <= op_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

endmodule

[rtl/core/piano_key_report_decoder.sv]
// Piano key report decoder: top level joining front end, queue and key store.
//
// in_i carries one report byte per request with its last-byte flag and a key
// index to query; out_o returns one result per request: report end,
// whether the report was taken, the queried key state after that byte and
// the most recent press velocity.
// An accepted request passes the queue entry and then the output register
// before its result is valid. One request is taken every cycle while the
// queue has room; the front end parses bytes in the accepting cycle, the
// two-entry queue carries the decoded operation, and the key store applies it
// into the output register. Reset clears all keys, sets the velocity to
// -32768 and the parser to expect a report id. When the receiver stalls the
// result holds, the queue fills, and in_i.ready drops once it holds two.
module piano_key_report_decoder #(
  parameter int unsigned NOTE_KEYS = 48,
  parameter int unsigned MASK_KEYS = 24
) (
  input logic        clk_i,
  input logic        rst_ni,
  pkd_in_if.sink     in_i,
  pkd_out_if.source  out_o
);

  logic          fe_valid, fe_ready;
  pkd_pkg::op_t  fe_op;
  logic          be_valid, be_ready;
  pkd_pkg::op_t  be_op;
  pkd_pkg::res_t res;

  pkd_front #(
    .NOTE_KEYS(NOTE_KEYS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .report_byte_i (in_i.report_byte),
    .last_byte_i   (in_i.last_byte),
    .query_button_i(in_i.query_button),
    .op_valid_o    (fe_valid),
    .op_ready_i    (fe_ready),
    .op_o          (fe_op)
  );

  pkd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fe_valid),
    .push_ready_o(fe_ready),
    .push_data_i (fe_op),
    .pop_valid_o (be_valid),
    .pop_ready_i (be_ready),
    .pop_data_o  (be_op)
  );

  pkd_back #(
    .NOTE_KEYS(NOTE_KEYS),
    .MASK_KEYS(MASK_KEYS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (be_valid),
    .op_ready_o (be_ready),
    .op_i       (be_op),
    .res_valid_o(out_o.valid),
    .res_ready_i(out_o.ready),
    .res_o      (res)
  );

  assign out_o.report_done    = res.done;
  assign out_o.report_handled = res.handled;
  assign out_o.button_down    = res.button;
  assign out_o.last_velocity  = res.velocity;

endmodule

[rtl/core/pkd_checker.sv]
// Port-level checker for the piano key report decoder and its bind.
`include "piano_key_report_decoder_macros.svh"

module pkd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               out_done_i,
  input logic               out_handled_i,
  input logic               out_button_i,
  input logic signed [15:0] out_velocity_i
);

  logic [2:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `PKD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable({out_done_i, out_handled_i, out_button_i, out_velocity_i}), "result changed while stalled")
  `PKD_ASSERT(a_handled_at_end, out_valid_i, out_done_i || !out_handled_i, "report taken without report end")
  `PKD_ASSERT(a_no_phantom, out_valid_i, pend_q != 3'd0, "result without a pending request")
  `PKD_ASSERT(a_pend_bound, in_valid_i || out_valid_i || 1'b1, pend_q <= 3'd3, "more requests in flight than storage")

endmodule

bind piano_key_report_decoder pkd_checker u_pkd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_done_i    (out_o.report_done),
  .out_handled_i (out_o.report_handled),
  .out_button_i  (out_o.button_down),
  .out_velocity_i(out_o.last_velocity)
);

[tb/sv/pkd_checker.sv]
// Checker for the piano key report decoder: predicts every result and compares it on arrival.
module pkd_scoreboard #(
  parameter int unsigned NOTE_KEYS = 48,
  parameter int unsigned MASK_KEYS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pkd_in_if           in_mon,
  pkd_out_if          out_mon,
  output int unsigned err_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOTAL_KEYS = NOTE_KEYS + MASK_KEYS;
  localparam int PRESS_BASE   = 8'h54 - 60;
  localparam int RELEASE_BASE = 8'h94 - 60;

  logic [TOTAL_KEYS-1:0] key_state;
  logic [15:0]           press_vel;
  logic [1:0]            byte_pos;
  pkd_pkg::kind_e        kind;
  logic [7:0]            held_note;
  logic [15:0]           mask_hi;
  pkd_pkg::res_t         expected_q[$];

  task automatic decode_request(input logic [7:0] b, input logic lst, input logic [6:0] q,
                                output pkd_pkg::res_t r);
    int          key;
    logic [23:0] mask;
    logic        handled;
    handled = 1'b0;
    if (byte_pos == 2'd0) begin
      if (b == pkd_pkg::ID_NOTES) begin
        kind = pkd_pkg::KIND_NOTES;
      end else if (b == pkd_pkg::ID_MASK) begin
        kind = pkd_pkg::KIND_MASK_WAIT;
      end else begin
        kind = pkd_pkg::KIND_NONE;
      end
      byte_pos = 2'd1;
    end else if (kind == pkd_pkg::KIND_NOTES) begin
      if (byte_pos == 2'd1) begin
        held_note = b;
        byte_pos  = 2'd2;
      end else begin
        if (held_note < pkd_pkg::PRESS_LIMIT) begin
          key = int'(held_note) - PRESS_BASE;
          if (key >= 0 && key < int'(NOTE_KEYS)) begin
            key_state[key] = 1'b1;
            press_vel = 16'((((b == 8'd0) ? 32'd1 : 32'(b)) * 32'd257)
                            + 32'(pkd_pkg::VEL_RESET));
          end
        end else begin
          key = int'(held_note) - RELEASE_BASE;
          if (key >= 0 && key < int'(NOTE_KEYS)) begin
            key_state[key] = 1'b0;
          end
        end
        byte_pos = 2'd1;
      end
    end else if (kind == pkd_pkg::KIND_MASK_WAIT) begin
      if (byte_pos == 2'd1) begin
        mask_hi  = {b, 8'h00};
        byte_pos = 2'd2;
      end else if (byte_pos == 2'd2) begin
        mask_hi[7:0] = b;
        byte_pos     = 2'd3;
      end else begin
        mask = {mask_hi, b};
        for (int i = 0; i < int'(MASK_KEYS); i++) begin
          key_state[NOTE_KEYS + i] = mask[i];
        end
        kind = pkd_pkg::KIND_MASK_DONE;
      end
    end
    if (lst) begin
      handled  = (kind == pkd_pkg::KIND_NOTES) || (kind == pkd_pkg::KIND_MASK_DONE);
      byte_pos = 2'd0;
      kind     = pkd_pkg::KIND_NONE;
    end
    r.done     = lst;
    r.handled  = handled;
    r.button   = (q < TOTAL_KEYS) ? key_state[q] : 1'b0;
    r.velocity = press_vel;
  endtask

  function automatic int field_mismatch(input string name, input int want, input int got);
    if (want == got) begin
      return 0;
    end
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pkd_pkg::res_t head;
    pkd_pkg::res_t next_res;
    int            fails;
    if (!rst_ni) begin
      key_state   = '0;
      press_vel   = pkd_pkg::VEL_RESET;
      byte_pos    = 2'd0;
      kind        = pkd_pkg::KIND_NONE;
      held_note   = 8'h00;
      mask_hi     = 16'h0000;
      expected_q.delete();
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      fails = 0;
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request pending, expected none actual done=%0b",
                   $time, out_mon.report_done);
          fails++;
        end else begin
          head = expected_q.pop_front();
          fails += field_mismatch("report_done", head.done, out_mon.report_done);
          fails += field_mismatch("report_handled", head.handled, out_mon.report_handled);
          fails += field_mismatch("button_down", head.button, out_mon.button_down);
          fails += field_mismatch("last_velocity", int'(head.velocity),
                                  int'(out_mon.last_velocity));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        decode_request(in_mon.report_byte, in_mon.last_byte, in_mon.query_button, next_res);
        expected_q.push_back(next_res);
      end
      err_count_o <= err_count_o + fails;
      pending_o   <= expected_q.size();
    end
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for the piano key report decoder: clock, reset, request stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NOTE_KEYS   = 48;
  localparam int unsigned MASK_KEYS   = 24;
  localparam int unsigned NUM_BYTES   = 650;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [7:0]  OTHER_ID    = 8'h05;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        quiet;
  int unsigned err_count;
  int unsigned pending;
  int unsigned sent;
  int unsigned stall_cycles;
  logic [7:0]  report_q[$];

  pkd_in_if  in_if ();
  pkd_out_if out_if ();

  piano_key_report_decoder #(
    .NOTE_KEYS(NOTE_KEYS),
    .MASK_KEYS(MASK_KEYS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  pkd_scoreboard #(
    .NOTE_KEYS(NOTE_KEYS),
    .MASK_KEYS(MASK_KEYS)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= quiet || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [6:0] pick_query();
    if ($urandom_range(0, 99) < 85) begin
      return 7'($urandom_range(0, NOTE_KEYS + MASK_KEYS - 1));
    end
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] pick_note();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 8'($urandom_range(24, 71));
    end else if (r < 85) begin
      return 8'($urandom_range(129, 183));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic [6:0] q);
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.report_byte  <= b;
    in_if.last_byte    <= lst;
    in_if.query_button <= q;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_report();
    for (int i = 0; i < report_q.size(); i++) begin
      send_byte(report_q[i], i == report_q.size() - 1, pick_query());
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_report();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    report_q.delete();
    if (r < 45) begin
      report_q.push_back(pkd_pkg::ID_NOTES);
      n = $urandom_range(0, 6);
      repeat (n) begin
        report_q.push_back(pick_note());
        report_q.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
        report_q.push_back(pick_note());
      end
    end else if (r < 80) begin
      report_q.push_back(pkd_pkg::ID_MASK);
      n = ($urandom_range(0, 99) < 80) ? 3 : $urandom_range(0, 5);
      repeat (n) report_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 90) begin
      report_q.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 4)) report_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 3)) report_q.push_back(8'($urandom_range(0, 255)));
    end
    send_report();
  endtask

  initial begin
    bit paused;
    rst_ni              = 1'b0;
    quiet               = 1'b0;
    sent                = 0;
    paused              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.report_byte   = 8'h00;
    in_if.last_byte     = 1'b0;
    in_if.query_button  = 7'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty note report
    send_byte(pkd_pkg::ID_NOTES, 1'b1, 7'd0);
    // lowest and highest press, zero velocity, out-of-range presses
    send_byte(pkd_pkg::ID_NOTES, 1'b0, 7'd0);
    send_byte(8'd24,    1'b0, 7'd0);
    send_byte(8'd0,     1'b0, 7'd0);
    send_byte(8'd71,    1'b0, 7'd47);
    send_byte(8'd255,   1'b0, 7'd47);
    send_byte(8'h80,    1'b0, 7'd104);
    send_byte(8'd7,     1'b0, 7'd127);
    send_byte(8'd23,    1'b0, 7'd72);
    send_byte(8'd9,     1'b1, 7'd71);
    // release, out-of-range release, odd trailing byte
    send_byte(pkd_pkg::ID_NOTES, 1'b0, 7'd0);
    send_byte(8'd135,   1'b0, 7'd47);
    send_byte(8'd1,     1'b0, 7'd47);
    send_byte(8'hFF,    1'b0, 7'd47);
    send_byte(8'd0,     1'b0, 7'd47);
    send_byte(8'd24,    1'b1, 7'd0);
    // full mask set
    send_byte(pkd_pkg::ID_MASK,  1'b0, 7'd48);
    send_byte(8'hFF,    1'b0, 7'd48);
    send_byte(8'hFF,    1'b0, 7'd71);
    send_byte(8'hFF,    1'b1, 7'd71);
    // short mask report
    send_byte(pkd_pkg::ID_MASK,  1'b0, 7'd60);
    send_byte(8'hAA,    1'b0, 7'd60);
    send_byte(8'hBB,    1'b1, 7'd60);
    // mask clear with extra byte
    send_byte(pkd_pkg::ID_MASK,  1'b0, 7'd48);
    send_byte(8'h00,    1'b0, 7'd48);
    send_byte(8'h00,    1'b0, 7'd48);
    send_byte(8'h00,    1'b0, 7'd71);
    send_byte(8'h5A,    1'b1, 7'd71);
    // unknown report id, bare mask id
    send_byte(OTHER_ID, 1'b0, 7'd0);
    send_byte(8'd24,    1'b1, 7'd0);
    send_byte(pkd_pkg::ID_MASK,  1'b1, 7'd48);

    sent = 0;
    while (sent < NUM_BYTES) begin
      quiet <= (sent >= 250) && (sent < 400);
      if (!paused && sent >= 500) begin
        paused = 1'b1;
        drain();
      end
      random_report();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/pkd_pkg.sv
rtl/core/pkd_in_if.sv
rtl/core/pkd_out_if.sv
rtl/core/pkd_front.sv
rtl/core/pkd_queue.sv
rtl/core/pkd_back.sv
rtl/core/piano_key_report_decoder.sv
rtl/core/pkd_checker.sv
tb/sv/pkd_checker.sv
tb/sv/tb.sv
